/* rtl/buddy_block_allocator_macros.svh */
// assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// implication checked on every edge outside reset
`define BBA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

/* rtl/bba_pkg.sv */
// ------------------------------------------------------------------
// bba_pkg
// types and constants shared by the buddy allocator modules
// ------------------------------------------------------------------
`default_nettype none
package bba_pkg;
    localparam int POOL_BYTES = 4096;
    localparam int MIN_BLOCK  = 8;
    localparam int LEAF_DEPTH = $clog2(POOL_BYTES / MIN_BLOCK);
    localparam int NODE_W     = LEAF_DEPTH + 1;
    localparam int NODES      = 1 << NODE_W;
    localparam int LV_W       = $clog2(LEAF_DEPTH + 1);

    localparam logic [1:0] ST_UNUSED = 2'd0;
    localparam logic [1:0] ST_FREE   = 2'd1;
    localparam logic [1:0] ST_SPLIT  = 2'd2;
    localparam logic [1:0] ST_ALLOC  = 2'd3;

    localparam logic [1:0] RS_OK     = 2'd0;
    localparam logic [1:0] RS_BIG    = 2'd1;
    localparam logic [1:0] RS_NOSPC  = 2'd2;
    localparam logic [1:0] RS_NOTAL  = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [12:0] request_size;
        logic [11:0] block_offset;
    } t_req;

    typedef struct packed {
        logic [11:0] granted_offset;
        logic [12:0] granted_size;
        logic [1:0]  status;
    } t_rsp;

    // memory port bundle from controller to node memory
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [1:0]        wr_data;
    } t_mem_cmd;
endpackage
`default_nettype wire

/* rtl/bba_node_mem.sv */
// ------------------------------------------------------------------
// bba_node_mem
// node status memory, one read and one write port, registered read,
// cleared by a sweep after reset
// ------------------------------------------------------------------
`default_nettype none
module bba_node_mem
    import bba_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_mem_cmd   i_cmd,
    output logic [1:0]      o_rd_data,
    output logic            o_ready
);
    logic [1:0] r_mem [NODES];
    logic [NODE_W:0] r_clr;
    logic [NODE_W:0] n_clr;
    logic            clearing;

    assign clearing = !r_clr[NODE_W];
    assign o_ready  = !clearing;
    assign n_clr    = clearing ? r_clr + 1'b1 : r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else begin
            r_clr <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_mem[r_clr[NODE_W-1:0]] <= (r_clr[NODE_W-1:0] == NODE_W'(1)) ? ST_FREE : ST_UNUSED;
        end else if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            o_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end
endmodule
`default_nettype wire

/* rtl/bba_ctrl.sv */
// ------------------------------------------------------------------
// bba_ctrl
// sequencer for alloc search, split, free descent and buddy merge
// ------------------------------------------------------------------
`default_nettype none
module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_req       i_req,
    input  wire logic       i_mem_ready,
    input  wire logic [1:0] i_rd_data,
    output t_mem_cmd        o_cmd,
    output logic            o_busy,
    output logic            o_done,
    output t_rsp            o_rsp
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_SPLIT = 3'd2;
    localparam logic [2:0] S_FDESC = 3'd3;
    localparam logic [2:0] S_MERGE = 3'd4;
    localparam logic [2:0] S_MWAIT = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [NODE_W-1:0] r_node, n_node;   // node whose data arrives this cycle
    logic [LV_W-1:0]   r_lv, n_lv;       // level of r_node
    logic [LV_W-1:0]   r_dlv, n_dlv;     // target level of alloc
    logic [11:0]       r_off, n_off;
    logic [11:0]       r_base, n_base;
    logic              r_pend, n_pend;   // read data valid in search and descent; step flag in split and merge
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;
    logic [12:0]       r_fsize, n_fsize;
    logic [LV_W-1:0]   dsel;
    t_mem_cmd          cmd;

    // round request up to the tree level
    always_comb begin
        dsel = LV_W'(LEAF_DEPTH);
        for (int k = LEAF_DEPTH; k >= 1; k--) begin
            if ((POOL_BYTES >> k) < int'(i_req.request_size) && dsel == LV_W'(k))
                dsel = LV_W'(k - 1);
        end
    end

    function automatic logic [12:0] lsize(input logic [LV_W-1:0] lv);
        lsize = 13'((POOL_BYTES >> lv));
    endfunction

    function automatic logic [NODE_W-1:0] first_of(input logic [LV_W-1:0] lv);
        first_of = NODE_W'(1) << lv;
    endfunction

    always_comb begin
        n_state = r_state;
        n_node  = r_node;
        n_lv    = r_lv;
        n_dlv   = r_dlv;
        n_off   = r_off;
        n_base  = r_base;
        n_pend  = 1'b0;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        n_fsize = r_fsize;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                // no new word while a result is shown
                if (i_start && i_mem_ready && !r_done) begin
                    n_rsp = '0;
                    if (!i_req.req_type) begin
                        if (i_req.request_size > 13'(POOL_BYTES)) begin
                            n_rsp.status = RS_BIG;
                            n_done = 1'b1;
                        end else begin
                            n_dlv  = dsel;
                            n_lv   = dsel;
                            n_node = first_of(dsel);
                            cmd.rd_en = 1'b1;
                            cmd.rd_addr = first_of(dsel);
                            n_pend = 1'b1;
                            n_state = S_SRCH;
                        end
                    end else begin
                        n_off  = i_req.block_offset;
                        n_base = '0;
                        n_lv   = '0;
                        n_node = NODE_W'(1);
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = NODE_W'(1);
                        n_pend = 1'b1;
                        n_state = S_FDESC;
                    end
                end
            end
            // scan one node a cycle, deepest adequate level first
            S_SRCH: begin
                if (i_rd_data == ST_FREE) begin
                    n_state = S_SPLIT;
                end else begin
                    if (r_node == ((first_of(r_lv) << 1) - 1'b1)) begin
                        if (r_lv == '0) begin
                            n_rsp.status = RS_NOSPC;
                            n_done = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_lv = r_lv - 1'b1;
                            n_node = first_of(r_lv - 1'b1);
                        end
                    end else begin
                        n_node = r_node + 1'b1;
                    end
                    if (n_state == S_SRCH) begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = n_node;
                        n_pend = 1'b1;
                    end
                end
            end
            // one write a cycle: right child free, then parent split, down left
            S_SPLIT: begin
                cmd.wr_en = 1'b1;
                if (r_lv == r_dlv) begin
                    cmd.wr_addr = r_node;
                    cmd.wr_data = ST_ALLOC;
                    n_rsp.granted_offset = 12'(32'(r_node - first_of(r_lv)) *
                                           32'(lsize(r_lv)));
                    n_rsp.granted_size = lsize(r_lv);
                    n_rsp.status = RS_OK;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else if (!r_pend) begin
                    cmd.wr_addr = {r_node[NODE_W-2:0], 1'b1};
                    cmd.wr_data = ST_FREE;
                    n_pend = 1'b1;
                end else begin
                    cmd.wr_addr = r_node;
                    cmd.wr_data = ST_SPLIT;
                    n_node = {r_node[NODE_W-2:0], 1'b0};
                    n_lv = r_lv + 1'b1;
                end
            end
            S_FDESC: begin
                if (i_rd_data == ST_SPLIT && r_lv != LV_W'(LEAF_DEPTH)) begin
                    n_lv = r_lv + 1'b1;
                    if ({1'b0, r_off} >= {1'b0, r_base} + lsize(r_lv + 1'b1)) begin
                        n_node = {r_node[NODE_W-2:0], 1'b1};
                        n_base = r_base + 12'(lsize(r_lv + 1'b1));
                    end else begin
                        n_node = {r_node[NODE_W-2:0], 1'b0};
                    end
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = n_node;
                    n_pend = 1'b1;
                end else if (i_rd_data != ST_ALLOC || r_base != r_off) begin
                    n_rsp.status = RS_NOTAL;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_fsize = lsize(r_lv);
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = r_node;
                    cmd.wr_data = ST_FREE;
                    n_state = S_MERGE;
                end
            end
            // r_node is free; read its buddy unless r_node is the root
            S_MERGE: begin
                if (r_node == NODE_W'(1)) begin
                    n_rsp.granted_size = r_fsize;
                    n_rsp.status = RS_OK;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = r_node ^ NODE_W'(1);
                    n_pend = 1'b0;
                    n_state = S_MWAIT;
                end
            end
            // buddy free: three writes: node, buddy unused; parent free; else done
            S_MWAIT: begin
                if (!r_pend && i_rd_data != ST_FREE) begin
                    n_rsp.granted_size = r_fsize;
                    n_rsp.status = RS_OK;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    cmd.wr_en = 1'b1;
                    if (!r_pend) begin
                        cmd.wr_addr = r_node;
                        cmd.wr_data = ST_UNUSED;
                        n_pend = 1'b1;
                        n_base = '0;
                    end else if (r_base == '0) begin
                        cmd.wr_addr = r_node ^ NODE_W'(1);
                        cmd.wr_data = ST_UNUSED;
                        n_pend = 1'b1;
                        n_base = 12'd1;
                    end else begin
                        cmd.wr_addr = r_node >> 1;
                        cmd.wr_data = ST_FREE;
                        n_node = r_node >> 1;
                        n_state = S_MERGE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_lv    <= n_lv;
        r_dlv   <= n_dlv;
        r_off   <= n_off;
        r_base  <= n_base;
        r_rsp   <= n_rsp;
        r_fsize <= n_fsize;
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE) || r_done || !i_mem_ready;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;
endmodule
`default_nettype wire

/* rtl/buddy_block_allocator.sv */
// ------------------------------------------------------------------
// buddy_block_allocator
// binary buddy allocator over a 4096-byte pool, 8-byte minimum block
// ------------------------------------------------------------------
// channel   ports                       handshake
// request   start, i_req, busy          taken when start && !busy
// result    o_done, o_rsp               one cycle, cannot be stalled
//
// alloc: scans up to 1023 nodes, then writes right child and parent at each split level;
// free: descends one tree level per read, then reads the buddy and writes at each merge level.
// both are paced by the single node memory port pair.
// after reset a clearing pass over all 1024 nodes runs with busy high.
// busy also stays high the cycle a result is shown.
`default_nettype none
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator
    import bba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);
    t_mem_cmd   cmd;
    logic [1:0] rd_data;
    logic       mem_ready;

    bba_node_mem u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .o_rd_data(rd_data), .o_ready(mem_ready)
    );

    bba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req(i_req),
        .i_mem_ready(mem_ready), .i_rd_data(rd_data), .o_cmd(cmd),
        .o_busy(busy), .o_done(o_done), .o_rsp(o_rsp)
    );

    `BBA_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `BBA_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_done && o_rsp.status != RS_OK,
        o_rsp.granted_size == '0 && o_rsp.granted_offset == '0)
    `BBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
endmodule
`default_nettype wire
